// File: rtl/windowed_chord_velocity_macros.svh
// assertion macros used by the checker
`ifndef WINDOWED_CHORD_VELOCITY_MACROS_SVH
`define WINDOWED_CHORD_VELOCITY_MACROS_SVH

// same-cycle implication, masked while in reset
`define WCV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define WCV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// implication checked at every edge, reset included
`define WCV_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/wcv_pkg.sv
package wcv_pkg;

    localparam int MAX_WINDOW_DEF = 63;
    localparam int KW             = 6;
    localparam int ADDR_W         = 4;

    localparam logic       MODE_SLIDING = 1'b0;
    localparam logic       MODE_JUMP    = 1'b1;
    localparam logic [5:0] WINDOW_MIN   = 6'd2;
    localparam logic [5:0] WINDOW_RST   = 6'd10;
    localparam logic [23:0] INVALID_RST = 24'hFFFF00;
    localparam logic [19:0] US_PER_S    = 20'd1000000;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_WINDOW  = 2'd1,
        REG_INVALID = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic        mode;
        logic [5:0]  size;
        logic [23:0] invalid;
    } cfg_t;

    typedef struct packed {
        logic [31:0] first_index;
        logic [KW-1:0] last_k;
        logic [31:0] total_base;
        logic [23:0] x_new;
        logic [23:0] y_new;
        logic [47:0] t_new;
        logic [23:0] x_old;
        logic [23:0] y_old;
        logic [47:0] t_old;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: rtl/wcv_if.sv
interface wcv_in_if;
    logic               valid;
    logic               ready;
    logic               restart;
    logic [47:0]        sample_time;
    logic signed [23:0] x_position;
    logic signed [23:0] y_position;

    modport source (output valid, restart, sample_time, x_position, y_position, input ready);
    modport sink (input valid, restart, sample_time, x_position, y_position, output ready);
endinterface

interface wcv_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_index;
    logic [31:0] velocity;
    logic        last_write;
    logic [31:0] valid_total;

    modport source (output valid, sample_index, velocity, last_write, valid_total, input ready);
    modport sink (input valid, sample_index, velocity, last_write, valid_total, output ready);
endinterface

// File: rtl/wcv_ram.sv
module wcv_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/wcv_front.sv
module wcv_front #(
    parameter int MAX_WINDOW = wcv_pkg::MAX_WINDOW_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wcv_in_if.sink        in_ch,
    input  wcv_pkg::cfg_t cfg,
    input  wcv_pkg::q_stat_t qstat,
    output logic          push,
    output wcv_pkg::job_t job
);
    import wcv_pkg::*;

    localparam int RING_AW    = $clog2(MAX_WINDOW + 1);
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam int SAMPLE_W   = 96;

    logic [31:0]   cnt_reg, cnt_next;
    logic [KW-1:0] skip_reg, skip_next;
    logic [31:0]   total_reg, total_next;
    logic          pend_reg, pend_next;
    logic          mode_reg;
    logic [KW-1:0] w_reg;
    logic [31:0]   first_reg;
    logic [KW-1:0] last_k_reg;
    logic [23:0]   x_new_reg, y_new_reg;
    logic [47:0]   t_new_reg;

    logic [5:0]    w;
    logic          accept;
    logic [31:0]   idx, start;
    logic [KW-1:0] skip_cur;
    logic [31:0]   total_cur;
    logic          go;
    logic [SAMPLE_W-1:0] old_sample;
    logic [23:0]   old_x;

    // window clamped to the legal span
    always_comb
    begin
        w = cfg.size;
        if (w < WINDOW_MIN)
        begin
            w = WINDOW_MIN;
        end
        else if (w > 6'(MAX_WINDOW))
        begin
            w = 6'(MAX_WINDOW);
        end
    end

    assign in_ch.ready = !pend_reg;
    assign accept      = in_ch.valid && in_ch.ready;

    assign idx       = in_ch.restart ? 32'd0 : cnt_reg;
    assign skip_cur  = in_ch.restart ? '0 : skip_reg;
    assign total_cur = in_ch.restart ? 32'd0 : total_reg;
    assign start     = idx - {26'd0, w};
    assign go        = (skip_cur == '0) && (idx >= {26'd0, w})
                       && (in_ch.x_position != cfg.invalid);

    wcv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (idx[RING_AW-1:0]),
        .wdata ({in_ch.sample_time, in_ch.x_position, in_ch.y_position}),
        .re    (accept),
        .raddr (start[RING_AW-1:0]),
        .rdata (old_sample)
    );

    assign old_x = old_sample[47:24];

    always_comb
    begin
        cnt_next   = cnt_reg;
        skip_next  = skip_reg;
        total_next = total_reg;
        pend_next  = pend_reg;
        push       = 1'b0;
        if (accept)
        begin
            cnt_next   = idx + 32'd1;
            total_next = total_cur;
            skip_next  = (skip_cur != '0) ? skip_cur - KW'(1) : skip_cur;
            pend_next  = go;
        end
        else if (pend_reg)
        begin
            if (old_x == cfg.invalid)
            begin
                pend_next = 1'b0;
            end
            else if (!qstat.full)
            begin
                push       = 1'b1;
                pend_next  = 1'b0;
                total_next = total_reg + {26'd0, last_k_reg} + 32'd1;
                if (mode_reg == MODE_JUMP)
                begin
                    skip_next = w_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            skip_reg  <= '0;
            total_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            skip_reg  <= skip_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= cfg.mode;
            w_reg      <= w;
            first_reg  <= (cfg.mode == MODE_JUMP) ? start : idx;
            last_k_reg <= (cfg.mode == MODE_JUMP) ? w : '0;
            x_new_reg  <= in_ch.x_position;
            y_new_reg  <= in_ch.y_position;
            t_new_reg  <= in_ch.sample_time;
        end
    end

    always_comb
    begin
        job.first_index = first_reg;
        job.last_k      = last_k_reg;
        job.total_base  = total_reg;
        job.x_new       = x_new_reg;
        job.y_new       = y_new_reg;
        job.t_new       = t_new_reg;
        job.t_old       = old_sample[95:48];
        job.x_old       = old_x;
        job.y_old       = old_sample[23:0];
    end
endmodule

// File: rtl/wcv_queue.sv
module wcv_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wcv_pkg::job_t    din,
    input  logic             pop,
    output wcv_pkg::job_t    dout,
    output wcv_pkg::q_stat_t stat
);
    import wcv_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign dout       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: rtl/wcv_back.sv
module wcv_back (
    input  logic             clk,
    input  logic             rst_n,
    input  wcv_pkg::job_t    job,
    input  wcv_pkg::q_stat_t qstat,
    output logic             pop,
    wcv_out_if.source        out_ch
);
    import wcv_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQUARE = 8'b0000_0010,
        ST_SUM    = 8'b0000_0100,
        ST_ROOT   = 8'b0000_1000,
        ST_SCALE  = 8'b0001_0000,
        ST_PREP   = 8'b0010_0000,
        ST_DIVIDE = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [24:0] dx_reg, dy_reg;
    logic [47:0]   dt_reg;
    logic [47:0]   sqx_reg, sqy_reg;
    logic [49:0]   rem_reg, root_reg, bit_reg;
    logic [25:0]   chord_reg;
    logic [47:0]   num_reg;
    logic          sat_reg;
    logic [47:0]   r_reg;
    logic [31:0]   low_reg, q_reg;
    logic [4:0]    div_cnt_reg;
    logic [31:0]   vel_reg;
    logic [31:0]   idx_reg, tot_reg;
    logic [KW-1:0] k_reg, last_k_reg;

    logic          out_valid_reg;
    logic [31:0]   out_index_reg, out_vel_reg, out_total_reg;
    logic          out_last_reg;

    logic signed [49:0] px, py;
    logic [49:0]   trial;
    logic [45:0]   prod;
    logic [48:0]   r_sh;
    logic          qbit;
    logic          load;

    assign px    = dx_reg * dx_reg;
    assign py    = dy_reg * dy_reg;
    assign trial = root_reg + bit_reg;
    assign prod  = chord_reg * US_PER_S;
    assign r_sh  = {r_reg, low_reg[31]};
    assign qbit  = (r_sh >= {1'b0, dt_reg});
    assign load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);
    assign pop   = (state_reg == ST_IDLE) && !qstat.empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (!qstat.empty) state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROOT;
            ST_ROOT:   if (bit_reg == '0) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_PREP;
            ST_PREP:   state_next = ST_DIVIDE;
            ST_DIVIDE: if (div_cnt_reg == '0) state_next = ST_EMIT;
            ST_EMIT:   if (load && (k_reg == last_k_reg)) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dx_reg     <= 25'($signed(job.x_new)) - 25'($signed(job.x_old));
                dy_reg     <= 25'($signed(job.y_new)) - 25'($signed(job.y_old));
                dt_reg     <= job.t_new - job.t_old;
                idx_reg    <= job.first_index;
                tot_reg    <= job.total_base;
                last_k_reg <= job.last_k;
                k_reg      <= '0;
            end
            ST_SQUARE:
            begin
                sqx_reg <= px[47:0];
                sqy_reg <= py[47:0];
            end
            ST_SUM:
            begin
                rem_reg  <= {2'b0, sqx_reg} + {2'b0, sqy_reg};
                root_reg <= '0;
                bit_reg  <= 50'd1 << 48;
            end
            ST_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    // round half up: remainder above root means past the midpoint
                    chord_reg <= root_reg[25:0] + 26'(rem_reg > root_reg);
                end
                else
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            ST_SCALE:
            begin
                num_reg <= {2'b0, prod} + {1'b0, dt_reg[47:1]};
            end
            ST_PREP:
            begin
                // quotient overflows 32 bits (or dt is zero)
                sat_reg     <= {32'd0, num_reg[47:32]} >= dt_reg;
                r_reg       <= {32'd0, num_reg[47:32]};
                low_reg     <= num_reg[31:0];
                q_reg       <= '0;
                div_cnt_reg <= 5'd31;
            end
            ST_DIVIDE:
            begin
                r_reg       <= qbit ? 48'(r_sh - {1'b0, dt_reg}) : r_sh[47:0];
                low_reg     <= low_reg << 1;
                q_reg       <= {q_reg[30:0], qbit};
                div_cnt_reg <= div_cnt_reg - 5'd1;
                if (div_cnt_reg == '0)
                begin
                    vel_reg <= sat_reg ? 32'hFFFF_FFFF : {q_reg[30:0], qbit};
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    idx_reg <= idx_reg + 32'd1;
                    tot_reg <= tot_reg + 32'd1;
                    k_reg   <= k_reg + KW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_index_reg <= idx_reg;
            out_vel_reg   <= vel_reg;
            out_last_reg  <= (k_reg == last_k_reg);
            out_total_reg <= tot_reg + 32'd1;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sample_index = out_index_reg;
    assign out_ch.velocity     = out_vel_reg;
    assign out_ch.last_write   = out_last_reg;
    assign out_ch.valid_total  = out_total_reg;
endmodule

// File: rtl/windowed_chord_velocity.sv
// windowed chord velocity: one position sample (time, x, y) per input request;
// once a record holds more than window_size samples, each sample yields the chord
// from the sample window_size back, divided by their time difference, as
// Q32.0 position units per second (all ones for a zero time difference).
// sliding mode writes one result per sample; jump mode writes window_size+1
// results, oldest index first, then passes over the next window_size samples.
// the front stage takes a request; when the sample starts a chord it holds off the
// next request until the far end has been read from the ring memory and the job
// queued (or dropped for an invalid far end). a two-entry job queue sits between
// it and the arithmetic back end, so samples are still taken while a chord is
// worked: two-stage square and sum, 25-step bit-serial root, scale, 32-step
// restoring divide, then one result per cycle while the output is taken.
// configure via apb at
// offsets 0x0 mode, 0x4 window size, 0x8 invalid x, only while idle.
module windowed_chord_velocity #(
    parameter int MAX_WINDOW = wcv_pkg::MAX_WINDOW_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    wcv_in_if.sink                    in_ch,
    wcv_out_if.source                 out_ch,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [wcv_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import wcv_pkg::*;

    // configuration registers
    logic        mode_reg;
    logic [5:0]  size_reg;
    logic [23:0] invalid_reg;

    logic        cfg_write;
    reg_idx_t    reg_sel;
    cfg_t        cfg;

    job_t        front_job, queue_job;
    logic        push, pop;
    q_stat_t     qstat;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_SLIDING;
            size_reg    <= WINDOW_RST;
            invalid_reg <= INVALID_RST;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_MODE:    mode_reg    <= pwdata[0];
                REG_WINDOW:  size_reg    <= pwdata[5:0];
                REG_INVALID: invalid_reg <= pwdata[23:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back, sign extended for the invalid marker
    always_comb
    begin
        case (reg_sel)
            REG_MODE:    prdata = {31'd0, mode_reg};
            REG_WINDOW:  prdata = {26'd0, size_reg};
            REG_INVALID: prdata = {{8{invalid_reg[23]}}, invalid_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg.mode    = mode_reg;
    assign cfg.size    = size_reg;
    assign cfg.invalid = invalid_reg;

    // front: ring write, index and skip bookkeeping, chord qualification
    wcv_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .cfg   (cfg),
        .qstat (qstat),
        .push  (push),
        .job   (front_job)
    );

    // short job queue decoupling front and back
    wcv_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_job),
        .pop   (pop),
        .dout  (queue_job),
        .stat  (qstat)
    );

    // back: root, divide and result emission
    wcv_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (queue_job),
        .qstat  (qstat),
        .pop    (pop),
        .out_ch (out_ch)
    );
endmodule

// File: rtl/wcv_checker.sv
`include "windowed_chord_velocity_macros.svh"

module wcv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] sample_index,
    input logic [31:0] velocity,
    input logic        last_write,
    input logic [31:0] valid_total
);
    // last accepted result, when it was not the final one of its burst
    logic        burst_reg;
    logic [31:0] prev_index_reg, prev_vel_reg, prev_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            burst_reg <= !last_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            prev_index_reg <= sample_index;
            prev_vel_reg   <= velocity;
            prev_total_reg <= valid_total;
        end
    end

    `WCV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable({sample_index, velocity, last_write, valid_total}),
        "stalled result changed")

    `WCV_ASSERT_NOW(a_burst_seq, clk, rst_n, out_valid && burst_reg,
        (sample_index == prev_index_reg + 32'd1) && (velocity == prev_vel_reg)
        && (valid_total == prev_total_reg + 32'd1),
        "burst results out of sequence")

    `WCV_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid,
        "result valid during reset")
endmodule

bind windowed_chord_velocity wcv_checker u_wcv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sample_index (out_ch.sample_index),
    .velocity     (out_ch.velocity),
    .last_write   (out_ch.last_write),
    .valid_total  (out_ch.valid_total)
);
